### src/lca_pkg.sv
// Shared types and constants for the lowest common ancestor block.
// No dependencies; imported by lca_store, lca_ctrl and the top level.
package lca_pkg;

    localparam int NODE_W      = 10;
    localparam int MAX_NODES   = 1 << NODE_W;
    localparam int LIFT_LEVELS = 11;
    localparam int LEVEL_W     = $clog2(LIFT_LEVELS);
    localparam int ANC_AW      = LEVEL_W + NODE_W;
    localparam int ANC_ENTRIES = LIFT_LEVELS * MAX_NODES;

    localparam logic [LEVEL_W-1:0] TOP_LEVEL = LEVEL_W'(LIFT_LEVELS - 1);

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_BUILD = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0]        command;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [NODE_W-1:0] node_depth;
    } request_t;

    typedef struct packed {
        logic [NODE_W-1:0] ancestor;
        logic              bad_node;
    } result_t;

    typedef struct packed {
        logic              dep_we;
        logic [NODE_W-1:0] dep_waddr;
        logic [NODE_W-1:0] dep_wdata;
        logic [NODE_W-1:0] dep_raddr_a;
        logic [NODE_W-1:0] dep_raddr_b;
        logic              anc_we;
        logic [ANC_AW-1:0] anc_waddr;
        logic [NODE_W-1:0] anc_wdata;
        logic [ANC_AW-1:0] anc_raddr_a;
        logic [ANC_AW-1:0] anc_raddr_b;
    } mem_req_t;

    typedef struct packed {
        logic [NODE_W-1:0] dep_a;
        logic [NODE_W-1:0] dep_b;
        logic [NODE_W-1:0] anc_a;
        logic [NODE_W-1:0] anc_b;
    } mem_rsp_t;

    // Ancestor table address: level in the upper bits, node in the lower bits.
    function automatic logic [ANC_AW-1:0] anc_addr(input logic [LEVEL_W-1:0] level,
                                                   input logic [NODE_W-1:0]  node);
        return {level, node};
    endfunction

endpackage

### src/lowest_common_ancestor_lifting.sv
// Lowest common ancestor by binary lifting: top level with the node count register.
// Depends on lca_pkg, lca_store and lca_ctrl.
//
// Issue a request with start while busy is low. A load is written as it is taken and
// a bad query answers on done in the cycle after it is taken. A build walks the
// ancestor table through its single dependent read chain: two ancestor reads and a
// write per entry. A valid query reads both depths, lifts the deeper node where
// needed, level by level from the top (ancestor read, then depth read), then reads
// both ancestors per level while the nodes still differ, plus a final parent read if
// they still differ. The result shows on result for exactly one cycle with done high
// and cannot be held off; it leaves the block in the cycle busy drops. The node count
// register accepts a write in any cycle (cfg_ready is tied high) and must only be
// changed while busy is low.
module lowest_common_ancestor_lifting (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  lca_pkg::request_t          request,
    output logic                       busy,
    output logic                       done,
    output lca_pkg::result_t           result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [lca_pkg::NODE_W-1:0] cfg_data
);
    import lca_pkg::*;

    logic [NODE_W-1:0] node_count_reg;
    mem_req_t          mem_req;
    mem_rsp_t          mem_rsp;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            node_count_reg <= cfg_data;
        end
    end

    lca_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .request    (request),
        .node_count (node_count_reg),
        .busy       (busy),
        .done       (done),
        .result     (result),
        .mem_req    (mem_req),
        .mem_rsp    (mem_rsp)
    );

    lca_store u_store (
        .clk     (clk),
        .mem_req (mem_req),
        .mem_rsp (mem_rsp)
    );

    // A result is only ever issued as the sequencer returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.bad_node) |-> (result.ancestor == '0))
        else $error("bad query with nonzero ancestor");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.command == CMD_QUERY && request.node_a == '0)
        |=> (done && result.bad_node))
        else $error("query on node zero not flagged");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.command != CMD_QUERY) |=> !done)
        else $error("result after a non-query request");

endmodule

### src/lca_store.sv
// Depth memory and ancestor table memory, one write and two read ports each.
// Depends on lca_pkg. Reads of node zero return zero.
module lca_store (
    input  logic              clk,
    input  lca_pkg::mem_req_t mem_req,
    output lca_pkg::mem_rsp_t mem_rsp
);
    import lca_pkg::*;

    logic [NODE_W-1:0] dep_mem [MAX_NODES];
    logic [NODE_W-1:0] anc_mem [ANC_ENTRIES];

    logic [NODE_W-1:0] dep_a_reg;
    logic [NODE_W-1:0] dep_b_reg;
    logic [NODE_W-1:0] anc_a_reg;
    logic [NODE_W-1:0] anc_b_reg;
    logic              zero_dep_a_reg;
    logic              zero_dep_b_reg;
    logic              zero_anc_a_reg;
    logic              zero_anc_b_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.dep_we)
        begin
            dep_mem[mem_req.dep_waddr] <= mem_req.dep_wdata;
        end
        dep_a_reg      <= dep_mem[mem_req.dep_raddr_a];
        dep_b_reg      <= dep_mem[mem_req.dep_raddr_b];
        zero_dep_a_reg <= (mem_req.dep_raddr_a == '0);
        zero_dep_b_reg <= (mem_req.dep_raddr_b == '0);
    end

    always_ff @(posedge clk)
    begin
        if (mem_req.anc_we)
        begin
            anc_mem[mem_req.anc_waddr] <= mem_req.anc_wdata;
        end
        anc_a_reg      <= anc_mem[mem_req.anc_raddr_a];
        anc_b_reg      <= anc_mem[mem_req.anc_raddr_b];
        zero_anc_a_reg <= (mem_req.anc_raddr_a[NODE_W-1:0] == '0);
        zero_anc_b_reg <= (mem_req.anc_raddr_b[NODE_W-1:0] == '0);
    end

    // Node zero is never written; force its entries to zero.
    assign mem_rsp.dep_a = zero_dep_a_reg ? '0 : dep_a_reg;
    assign mem_rsp.dep_b = zero_dep_b_reg ? '0 : dep_b_reg;
    assign mem_rsp.anc_a = zero_anc_a_reg ? '0 : anc_a_reg;
    assign mem_rsp.anc_b = zero_anc_b_reg ? '0 : anc_b_reg;

endmodule

### src/lca_ctrl.sv
// Sequencer for load, table build and query; drives the store's ports.
// Depends on lca_pkg; the memories live in lca_store.
module lca_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  lca_pkg::request_t       request,
    input  logic [lca_pkg::NODE_W-1:0] node_count,
    output logic                    busy,
    output logic                    done,
    output lca_pkg::result_t        result,
    output lca_pkg::mem_req_t       mem_req,
    input  lca_pkg::mem_rsp_t       mem_rsp
);
    import lca_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_B_RD1,
        S_B_RD2,
        S_B_WR,
        S_Q_DEP,
        S_L_CHK,
        S_L_ANC,
        S_L_DEP,
        S_M_RD,
        S_M_CMP,
        S_FIN,
        S_FIN_RD
    } state_t;

    state_t            state_reg, state_next;
    logic              done_reg, done_next;
    result_t           result_reg, result_next;

    logic [NODE_W-1:0]  a_reg, a_next;
    logic [NODE_W-1:0]  b_reg, b_next;
    logic [NODE_W-1:0]  da_reg, da_next;
    logic [NODE_W-1:0]  db_reg, db_next;
    logic [NODE_W-1:0]  nb_reg, nb_next;
    logic [NODE_W-1:0]  node_reg, node_next;
    logic [LEVEL_W-1:0] level_reg, level_next;

    logic [NODE_W-1:0]  diff;
    logic [LEVEL_W-1:0] level_dec;
    logic               bad;

    assign diff      = (db_reg >= da_reg) ? (db_reg - da_reg) : '0;
    assign level_dec = level_reg - 1'b1;
    assign bad       = (request.node_a == '0) || (request.node_b == '0) ||
                       (request.node_a > node_count) || (request.node_b > node_count);

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        da_next     = da_reg;
        db_next     = db_reg;
        nb_next     = nb_reg;
        node_next   = node_reg;
        level_next  = level_reg;
        mem_req     = '0;

        case (state_reg)
            S_IDLE:
            begin
                mem_req.dep_raddr_a = request.node_a;
                mem_req.dep_raddr_b = request.node_b;
                if (start)
                begin
                    case (request.command)
                        CMD_LOAD:
                        begin
                            if (request.node_a != '0)
                            begin
                                mem_req.dep_we    = 1'b1;
                                mem_req.dep_waddr = request.node_a;
                                mem_req.dep_wdata = request.node_depth;
                                mem_req.anc_we    = 1'b1;
                                mem_req.anc_waddr = anc_addr('0, request.node_a);
                                mem_req.anc_wdata = request.node_b;
                            end
                        end
                        CMD_BUILD:
                        begin
                            if (node_count != '0)
                            begin
                                level_next = LEVEL_W'(1);
                                node_next  = NODE_W'(1);
                                state_next = S_B_RD1;
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (bad)
                            begin
                                done_next            = 1'b1;
                                result_next.ancestor = '0;
                                result_next.bad_node = 1'b1;
                            end
                            else
                            begin
                                a_next     = request.node_a;
                                b_next     = request.node_b;
                                state_next = S_Q_DEP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_B_RD1:
            begin
                mem_req.anc_raddr_a = anc_addr(level_dec, node_reg);
                state_next          = S_B_RD2;
            end

            S_B_RD2:
            begin
                mem_req.anc_raddr_a = anc_addr(level_dec, mem_rsp.anc_a);
                state_next          = S_B_WR;
            end

            S_B_WR:
            begin
                mem_req.anc_we    = 1'b1;
                mem_req.anc_waddr = anc_addr(level_reg, node_reg);
                mem_req.anc_wdata = mem_rsp.anc_a;
                state_next        = S_B_RD1;
                if (node_reg == node_count)
                begin
                    node_next = NODE_W'(1);
                    if (level_reg == TOP_LEVEL)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        level_next = level_reg + 1'b1;
                    end
                end
                else
                begin
                    node_next = node_reg + 1'b1;
                end
            end

            S_Q_DEP:
            begin
                // Keep the shallower node in a.
                if (mem_rsp.dep_b < mem_rsp.dep_a)
                begin
                    a_next  = b_reg;
                    b_next  = a_reg;
                    da_next = mem_rsp.dep_b;
                    db_next = mem_rsp.dep_a;
                end
                else
                begin
                    da_next = mem_rsp.dep_a;
                    db_next = mem_rsp.dep_b;
                end
                level_next = TOP_LEVEL;
                state_next = S_L_CHK;
            end

            S_L_CHK:
            begin
                if ((diff >> level_reg) != '0)
                begin
                    mem_req.anc_raddr_a = anc_addr(level_reg, b_reg);
                    state_next          = S_L_ANC;
                end
                else if (level_reg == '0)
                begin
                    level_next = TOP_LEVEL;
                    state_next = S_M_RD;
                end
                else
                begin
                    level_next = level_dec;
                end
            end

            S_L_ANC:
            begin
                nb_next             = mem_rsp.anc_a;
                mem_req.dep_raddr_a = mem_rsp.anc_a;
                state_next          = S_L_DEP;
            end

            S_L_DEP:
            begin
                if (da_reg <= mem_rsp.dep_a)
                begin
                    b_next  = nb_reg;
                    db_next = mem_rsp.dep_a;
                end
                if (level_reg == '0)
                begin
                    level_next = TOP_LEVEL;
                    state_next = S_M_RD;
                end
                else
                begin
                    level_next = level_dec;
                    state_next = S_L_CHK;
                end
            end

            S_M_RD:
            begin
                if (a_reg == b_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    mem_req.anc_raddr_a = anc_addr(level_reg, a_reg);
                    mem_req.anc_raddr_b = anc_addr(level_reg, b_reg);
                    state_next          = S_M_CMP;
                end
            end

            S_M_CMP:
            begin
                if (mem_rsp.anc_a != mem_rsp.anc_b)
                begin
                    a_next = mem_rsp.anc_a;
                    b_next = mem_rsp.anc_b;
                end
                if (level_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    level_next = level_dec;
                    state_next = S_M_RD;
                end
            end

            S_FIN:
            begin
                if (a_reg == b_reg)
                begin
                    done_next            = 1'b1;
                    result_next.ancestor = a_reg;
                    result_next.bad_node = 1'b0;
                    state_next           = S_IDLE;
                end
                else
                begin
                    mem_req.anc_raddr_a = anc_addr('0, a_reg);
                    state_next          = S_FIN_RD;
                end
            end

            S_FIN_RD:
            begin
                done_next            = 1'b1;
                result_next.ancestor = mem_rsp.anc_a;
                result_next.bad_node = 1'b0;
                state_next           = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        da_reg    <= da_next;
        db_reg    <= db_next;
        nb_reg    <= nb_next;
        node_reg  <= node_next;
        level_reg <= level_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

### dv/lca_result_checker.sv
// Checker for the lowest common ancestor block: predicts each query answer and compares.
// Depends on lca_pkg; instantiated by lowest_common_ancestor_lifting_tb beside the block.
module lca_result_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  lca_pkg::request_t          request,
    input  logic                       done,
    input  lca_pkg::result_t           result,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [lca_pkg::NODE_W-1:0] cfg_data,
    output int                         mismatches,
    output int                         waiting
);
    timeunit 1ns;
    timeprecision 1ps;
    import lca_pkg::*;

    localparam int ANSWER_SLOTS = 16;

    logic [NODE_W-1:0] count_reg;
    logic [NODE_W-1:0] depth_of [MAX_NODES];
    logic [NODE_W-1:0] hop [LIFT_LEVELS][MAX_NODES];
    result_t           answers [ANSWER_SLOTS];
    int                rd_ptr;
    int                wr_ptr;
    int                pending;
    result_t           want;
    int                fail_cnt;

    function automatic result_t common_ancestor(input logic [NODE_W-1:0] a,
                                                input logic [NODE_W-1:0] b);
        result_t           r;
        logic [NODE_W-1:0] lo;
        logic [NODE_W-1:0] hi;
        logic [NODE_W-1:0] nxt;
        logic [NODE_W-1:0] pa;
        logic [NODE_W-1:0] pb;
        int                gap;
        r = '0;
        if (a == 0 || b == 0 || a > count_reg || b > count_reg)
        begin
            r.bad_node = 1'b1;
            return r;
        end
        lo = a;
        hi = b;
        if (depth_of[hi] < depth_of[lo])
        begin
            lo = b;
            hi = a;
        end
        // lift the deeper node toward the depth of the other
        for (int k = LIFT_LEVELS - 1; k >= 0; k--)
        begin
            gap = (depth_of[hi] < depth_of[lo]) ? 0 : int'(depth_of[hi]) - int'(depth_of[lo]);
            if ((gap >> k) != 0)
            begin
                nxt = hop[k][hi];
                if (depth_of[lo] <= depth_of[nxt])
                    hi = nxt;
            end
        end
        // lift both while their ancestors differ
        for (int k = LIFT_LEVELS - 1; k >= 0 && lo != hi; k--)
        begin
            pa = hop[k][lo];
            pb = hop[k][hi];
            if (pa != pb)
            begin
                lo = pa;
                hi = pb;
            end
        end
        if (lo != hi)
            lo = hop[0][lo];
        r.ancestor = lo;
        return r;
    endfunction

    task automatic rebuild_table();
        for (int k = 1; k < LIFT_LEVELS; k++)
            for (int n = 1; n <= int'(count_reg); n++)
                hop[k][n] = hop[k-1][hop[k-1][n]];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg = NODE_W'(1);
            foreach (depth_of[i])
                depth_of[i] = '0;
            foreach (hop[k, n])
                hop[k][n] = '0;
            rd_ptr = 0;
            wr_ptr = 0;
            pending = 0;
            fail_cnt = 0;
            mismatches <= 0;
            waiting <= 0;
        end
        else
        begin
            // compare before taking a new request so a same-edge query cannot match early
            if (done)
            begin
                if (pending == 0)
                begin
                    fail_cnt++;
                    $display("%0t: expected no result, actual ancestor %0d bad_node %0d",
                             $time, result.ancestor, result.bad_node);
                end
                else
                begin
                    want = answers[rd_ptr];
                    rd_ptr = (rd_ptr + 1) % ANSWER_SLOTS;
                    pending--;
                    if (result.ancestor !== want.ancestor)
                    begin
                        fail_cnt++;
                        $display("%0t: ancestor expected %0d actual %0d",
                                 $time, want.ancestor, result.ancestor);
                    end
                    if (result.bad_node !== want.bad_node)
                    begin
                        fail_cnt++;
                        $display("%0t: bad_node expected %0d actual %0d",
                                 $time, want.bad_node, result.bad_node);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                count_reg = cfg_data;
            if (start && !busy)
            begin
                case (request.command)
                    CMD_LOAD:
                        if (request.node_a != 0)
                        begin
                            depth_of[request.node_a] = request.node_depth;
                            hop[0][request.node_a] = request.node_b;
                        end
                    CMD_BUILD:
                        rebuild_table();
                    CMD_QUERY:
                    begin
                        answers[wr_ptr] = common_ancestor(request.node_a, request.node_b);
                        wr_ptr = (wr_ptr + 1) % ANSWER_SLOTS;
                        pending++;
                    end
                    default:
                        ;
                endcase
            end
            mismatches <= fail_cnt;
            waiting <= pending;
        end
    end

endmodule

### dv/lowest_common_ancestor_lifting_tb.sv
// Top of the lowest common ancestor testbench: clock, reset, tree loading and query stimulus.
// Depends on lca_pkg, lowest_common_ancestor_lifting and lca_result_checker.
module lowest_common_ancestor_lifting_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lca_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         ITEM_TARGET = 1700;

    typedef enum int {CHAIN, BUSHY, BROAD} shape_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              start     = 1'b0;
    request_t          request   = '0;
    logic              cfg_valid = 1'b0;
    logic [NODE_W-1:0] cfg_data  = '0;
    logic              busy;
    logic              done;
    result_t           result;
    logic              cfg_ready;
    int                mismatches;
    int                waiting;

    int parent_of [MAX_NODES];
    int depth_of [MAX_NODES];
    int span;
    int items;
    bit calm;

    lowest_common_ancestor_lifting dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .request   (request),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    lca_result_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .request    (request),
        .done       (done),
        .result     (result),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .waiting    (waiting)
    );

    always #5 clk = ~clk;

    task automatic send(input logic [1:0] cmd, input int a, input int b, input int d);
        request_t r;
        r.command    = cmd;
        r.node_a     = NODE_W'(a);
        r.node_b     = NODE_W'(b);
        r.node_depth = NODE_W'(d);
        while (!calm && $urandom_range(99) < 25)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        items++;
    endtask

    // write node_count once the block has drained
    task automatic set_count(input int n);
        start <= 1'b0;
        repeat (4) @(posedge clk);
        while (busy || waiting != 0)
            @(posedge clk);
        repeat (4 + $urandom_range(0, 3)) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= NODE_W'(n);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        span = n;
    endtask

    task automatic load_tree(input int n, input shape_t shape);
        int p;
        for (int v = 1; v <= n; v++)
        begin
            if (v == 1)
                p = 0;
            else if (shape == CHAIN)
                p = v - 1 - $urandom_range(0, (v > 2) ? 1 : 0);
            else if (shape == BUSHY)
                p = ($urandom_range(99) < 3) ? 0 : $urandom_range(1, v - 1);
            else
                p = $urandom_range(1, (v - 1 < 3) ? v - 1 : 3);
            parent_of[v] = p;
            depth_of[v] = (p == 0) ? 0 : depth_of[p] + 1;
            send(CMD_LOAD, v, p, depth_of[v]);
        end
    endtask

    function automatic int climb(input int v);
        int u;
        int steps;
        u = v;
        steps = $urandom_range(0, 24);
        while (steps > 0 && parent_of[u] != 0)
        begin
            u = parent_of[u];
            steps--;
        end
        return u;
    endfunction

    task automatic run_queries(input int count);
        int roll;
        int a;
        int b;
        int t;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 70)
            begin
                a = $urandom_range(1, span);
                t = $urandom_range(9);
                b = (t < 5) ? $urandom_range(1, span) : (t < 8) ? climb(a) : a;
                if ($urandom_range(1))
                    send(CMD_QUERY, b, a, $urandom_range(1023));
                else
                    send(CMD_QUERY, a, b, $urandom_range(1023));
            end
            else if (roll < 78)
            begin
                a = ($urandom_range(1) || span == 1023) ? 0 : $urandom_range(span + 1, 1023);
                b = $urandom_range(1023);
                if ($urandom_range(1))
                    send(CMD_QUERY, a, b, $urandom_range(1023));
                else
                    send(CMD_QUERY, b, a, $urandom_range(1023));
            end
            else if (roll < 84)
                send(CMD_LOAD, 0, $urandom_range(1023), $urandom_range(1023));
            else if (roll < 88)
                send(CMD_UNUSED, $urandom_range(1023), $urandom_range(1023),
                     $urandom_range(1023));
            else if (roll < 93)
                send(CMD_LOAD, (span < 1023) ? $urandom_range(span + 1, 1023) : 0,
                     $urandom_range(1023), $urandom_range(1023));
            else if (roll < 97)
            begin
                // reload a live node with arbitrary parent and depth
                a = $urandom_range(1, span);
                parent_of[a] = $urandom_range(0, span);
                depth_of[a] = $urandom_range(1023);
                send(CMD_LOAD, a, parent_of[a], depth_of[a]);
            end
            else
                send(CMD_BUILD, $urandom_range(1023), $urandom_range(1023), $urandom_range(1023));
        end
    endtask

    initial
    begin
        #100_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int dir_parent [8];
        int qa [10];
        int qb [10];
        int n;
        dir_parent = '{0, 0, 1, 1, 2, 4, 5, 3};
        qa = '{6, 6, 5, 1, 4, 6, 5, 7, 8, 1023};
        qb = '{7, 4, 5, 6, 6, 2, 3, 0, 1, 1023};
        items = 0;
        calm = 1'b0;
        span = 1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: ignored items and bad queries at the reset count of one
        send(CMD_LOAD, 0, 1023, 1023);
        send(CMD_UNUSED, 1023, 1023, 1023);
        send(CMD_QUERY, 0, 0, 0);
        send(CMD_QUERY, 1, 2, 1023);

        // directed: small known tree
        set_count(7);
        for (int v = 1; v <= 7; v++)
        begin
            parent_of[v] = dir_parent[v];
            depth_of[v] = (dir_parent[v] == 0) ? 0 : depth_of[dir_parent[v]] + 1;
            send(CMD_LOAD, v, parent_of[v], depth_of[v]);
        end
        send(CMD_BUILD, 0, 0, 0);
        for (int i = 0; i < 10; i++)
            send(CMD_QUERY, qa[i], qb[i], 0);

        // full-size deep tree, loaded back to back
        set_count(1023);
        calm = 1'b1;
        load_tree(1023, CHAIN);
        send(CMD_BUILD, 0, 0, 0);
        calm = 1'b0;
        run_queries(150);

        // many small trees of varied shape
        n = 1;
        while (items < ITEM_TARGET)
        begin
            set_count(n);
            calm = ($urandom_range(9) == 0);
            load_tree(n, shape_t'($urandom_range(2)));
            send(CMD_BUILD, 0, 0, 0);
            run_queries($urandom_range(20, 60));
            calm = 1'b0;
            n = $urandom_range(1) ? $urandom_range(2, 16) : $urandom_range(17, 80);
        end

        start <= 1'b0;
        do
            @(posedge clk);
        while (busy || waiting != 0);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && waiting == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
